### rtl/core/plc_pkg.sv
// shared types and codes for the positional list store
package plc_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_READ      = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_REVERSE   = 3'd4,
    ACT_CLEAR     = 3'd5
  } plc_action_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } plc_ctl_t;

  localparam int unsigned ActionWidth   = 3;
  localparam int unsigned PositionWidth = 5;
  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned LengthWidth   = 5;
  localparam int unsigned InTdataWidth  = 40;
  localparam int unsigned OutTdataWidth = 40;

endpackage

### rtl/core/positional_list_store.sv
// top level of the positional list store: control, length, direction and cell chain
//
// Ordered list of up to CAPACITY words addressed by 1-based position.
// Input channel s_*: one transaction carries action, position and value.
// Output channel m_*: one transaction per input carries ok, read_data and the
// length after the action.
// Every action completes in the cycle it is accepted: the cell chain shifts
// all entries at once on insert or remove, so one transaction per cycle is
// sustained while m_tready does not stall. The result is registered and
// appears on m_* in the cycle after acceptance. It sits in a single output
// register; s_tready is high while that register is empty or being taken, so
// a stall on m_tready holds the result and stops input acceptance until it is taken.
// Reverse flips a direction bit instead of moving data; clear sets the
// length to zero and leaves the cells as they are.
// Reset (rst, synchronous) empties the list, clears the direction bit and
// drops any pending result. Cell contents are not reset; only entries below
// the length are ever read.
module positional_list_store
  import plc_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // action [2:0], position [7:3], value [39:8]
  input  logic [InTdataWidth-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // ok [0], read_data [32:1], length [37:33], zero [39:38]
  output logic [OutTdataWidth-1:0] m_tdata
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned WW = ((CW > PositionWidth) ? CW : PositionWidth) + 1;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           reversed;
  logic           reversed_next;
  logic           accept;

  plc_action_t    act;
  logic [WW-1:0]  pos_w;
  logic [WW-1:0]  cnt_w;
  logic [WW-1:0]  slot_ins_w;
  logic [WW-1:0]  slot_oth_w;
  logic [IW-1:0]  slot;
  logic           ins_ok;
  logic           pos_ok;
  logic           ok_c;
  plc_ctl_t       ctl;
  logic [63:0]    value_ext;
  logic [DATA_WIDTH-1:0] value_dw;
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [63:0]    rd_ext;
  logic [ValueWidth-1:0] rd_c;
  logic [15:0]    len_ext;

  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign act       = plc_action_t'(s_tdata[2:0]);
  assign pos_w     = WW'(s_tdata[7:3]);
  assign cnt_w     = WW'(count);
  assign value_ext = 64'(s_tdata[39:8]);
  assign value_dw  = value_ext[DATA_WIDTH-1:0];

  assign ins_ok = (pos_w >= WW'(1)) && (pos_w <= cnt_w + WW'(1)) && (cnt_w < WW'(CAPACITY));
  assign pos_ok = (pos_w >= WW'(1)) && (pos_w <= cnt_w);

  // mirrored mapping while the direction bit is set
  assign slot_ins_w = reversed ? (cnt_w + WW'(1) - pos_w) : (pos_w - WW'(1));
  assign slot_oth_w = reversed ? (cnt_w - pos_w) : (pos_w - WW'(1));
  assign slot       = (act == ACT_INSERT) ? slot_ins_w[IW-1:0] : slot_oth_w[IW-1:0];

  always_comb begin
    ok_c          = 1'b0;
    ctl           = '0;
    count_next    = count;
    reversed_next = reversed;
    case (act)
      ACT_INSERT: begin
        ok_c = ins_ok;
        if (ins_ok) begin
          ctl.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      ACT_REMOVE: begin
        ok_c = pos_ok;
        if (pos_ok) begin
          ctl.rem    = accept;
          count_next = count - CW'(1);
        end
      end
      ACT_READ: begin
        ok_c = pos_ok;
      end
      ACT_OVERWRITE: begin
        ok_c   = pos_ok;
        ctl.wr = accept && pos_ok;
      end
      ACT_REVERSE: begin
        ok_c          = 1'b1;
        reversed_next = !reversed;
      end
      ACT_CLEAR: begin
        ok_c       = 1'b1;
        count_next = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = value_dw;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    plc_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_WIDTH  (IW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot       (slot),
      .value      (value_dw),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  assign rd_ext  = 64'(rd_sel);
  assign rd_c    = ((act == ACT_READ) && pos_ok) ? rd_ext[ValueWidth-1:0] : '0;
  assign len_ext = 16'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      reversed <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        reversed <= reversed_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, len_ext[LengthWidth-1:0], rd_c, ok_c};
    end
  end

  logic [15:0] cnt_ext;
  assign cnt_ext = 16'(count);

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    cnt_w <= WW'(CAPACITY))
    else $error("list length beyond capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    accept && (act == ACT_INSERT) && ins_ok |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_refused_hold : assert property (@(posedge clk) disable iff (rst)
    accept && !ok_c |=> (count == $past(count)) && (reversed == $past(reversed)))
    else $error("refused action changed state");

  a_len_tracks : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:33] == cnt_ext[LengthWidth-1:0])
    else $error("reported length differs from stored length");

endmodule

### rtl/core/plc_cell.sv
// one storage cell of the list chain: holds one entry, shifts with its neighbors
module plc_cell
  import plc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_WIDTH  = 4,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk,
  input  plc_ctl_t              ctl,
  input  logic [IDX_WIDTH-1:0]  slot,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(IDX);

  logic                  eq;
  logic                  above;
  logic [DATA_WIDTH-1:0] data_next;

  assign eq    = (slot == MyIdx);
  assign above = (MyIdx > slot);

  always_comb begin
    data_next = data;
    if (ctl.ins && above) begin
      data_next = left_data;
    end else if (ctl.ins && eq) begin
      data_next = value;
    end else if (ctl.rem && (eq || above)) begin
      data_next = right_data;
    end else if (ctl.wr && eq) begin
      data_next = value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // only the addressed cell drives the read bus
  assign rd_data = eq ? data : '0;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the positional list store
module testbench;
  import plc_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned StallLimit  = 4000;

  // codes outside the defined action set, refused by the block
  localparam logic [ActionWidth-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ActionWidth-1:0] ACT_SPARE_7 = 3'd7;
  localparam logic [ValueWidth-1:0]  AllOnes     = '1;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int unsigned {SEQ_NOISE, SEQ_GROW, SEQ_SHRINK, SEQ_MIXED} seq_style_t;

  typedef struct packed {
    logic [ValueWidth-1:0]    value;
    logic [PositionWidth-1:0] position;
    logic [ActionWidth-1:0]   action;
  } list_cmd_t;

  typedef struct {
    list_cmd_t  cmd;
    idle_mode_t mode;
  } queued_cmd_t;

  typedef struct packed {
    logic                   ok;
    logic [ValueWidth-1:0]  read_data;
    logic [LengthWidth-1:0] length;
  } list_result_t;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [InTdataWidth-1:0]  s_tdata  = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_tdata;

  queued_cmd_t  cmd_queue[$];
  list_result_t due_results[$];
  idle_mode_t   active_mode = IDLE_NONE;
  idle_mode_t   mode_plan[5] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

  // predicted list contents
  logic [ValueWidth-1:0] list_cells[Depth];
  int unsigned           list_len = 0;
  logic                  list_rev = 1'b0;

  // length as seen while building the stimulus
  int unsigned gen_len = 0;

  int unsigned error_count = 0;
  int unsigned checked     = 0;
  int unsigned refused     = 0;
  int unsigned peak_len    = 0;
  int unsigned idle_cycles = 0;

  positional_list_store #(
    .CAPACITY  (Depth),
    .DATA_WIDTH(ValueWidth)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned slot_of(int unsigned p);
    return list_rev ? list_len - p : p - 1;
  endfunction

  function automatic list_result_t apply_list_op(list_cmd_t c);
    list_result_t r;
    int unsigned  p, s, i;
    r = '0;
    p = 32'(c.position);
    case (c.action)
      ACT_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < Depth) begin
          s = list_rev ? list_len + 1 - p : p - 1;
          for (i = list_len; i > s; i--) list_cells[i] = list_cells[i - 1];
          list_cells[s] = c.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (p >= 1 && p <= list_len) begin
          s = slot_of(p);
          for (i = s; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      ACT_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.read_data = list_cells[slot_of(p)];
          r.ok = 1'b1;
        end
      end
      ACT_OVERWRITE: begin
        if (p >= 1 && p <= list_len) begin
          list_cells[slot_of(p)] = c.value;
          r.ok = 1'b1;
        end
      end
      ACT_REVERSE: begin
        list_rev = !list_rev;
        r.ok = 1'b1;
      end
      ACT_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.length = LengthWidth'(list_len);
    return r;
  endfunction

  function automatic void queue_cmd(logic [ActionWidth-1:0] action, int unsigned pos,
                                    logic [ValueWidth-1:0] value, idle_mode_t mode);
    queued_cmd_t q;
    q.cmd.action   = action;
    q.cmd.position = pos[PositionWidth-1:0];
    q.cmd.value    = value;
    q.mode         = mode;
    cmd_queue.push_back(q);
    case (action)
      ACT_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < Depth) gen_len++;
      ACT_REMOVE: if (pos >= 1 && pos <= gen_len) gen_len--;
      ACT_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endfunction

  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return AllOnes;
    return $urandom;
  endfunction

  function automatic logic [ActionWidth-1:0] pick_action(seq_style_t style);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (style)
      SEQ_GROW: begin
        if (roll < 65) return ACT_INSERT;
        if (roll < 73) return ACT_REMOVE;
        if (roll < 86) return ACT_READ;
        if (roll < 95) return ACT_OVERWRITE;
        return ACT_REVERSE;
      end
      SEQ_SHRINK: begin
        if (roll < 15) return ACT_INSERT;
        if (roll < 60) return ACT_REMOVE;
        if (roll < 78) return ACT_READ;
        if (roll < 90) return ACT_OVERWRITE;
        if (roll < 97) return ACT_REVERSE;
        return ACT_CLEAR;
      end
      default: begin
        if (roll < 30) return ACT_INSERT;
        if (roll < 50) return ACT_REMOVE;
        if (roll < 72) return ACT_READ;
        if (roll < 88) return ACT_OVERWRITE;
        if (roll < 96) return ACT_REVERSE;
        return ACT_CLEAR;
      end
    endcase
  endfunction

  function automatic int unsigned pick_position(logic [ActionWidth-1:0] action);
    int unsigned top;
    top = (action == ACT_INSERT) ? gen_len + 1 : gen_len;
    // now and then just outside the legal range
    if (top == 0 || $urandom_range(0, 99) < 8) return $urandom_range(0, 1) ? 0 : top + 1;
    return $urandom_range(1, top);
  endfunction

  function automatic int unsigned sender_idle_pct(idle_mode_t mode);
    return (mode == IDLE_SENDER) ? 86 : (mode == IDLE_BOTH) ? 27 : 0;
  endfunction

  function automatic int unsigned receiver_stall_pct(idle_mode_t mode);
    return (mode == IDLE_RECEIVER) ? 86 : (mode == IDLE_BOTH) ? 27 : 0;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // driver: predicts each accepted transaction, then loads the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_list_op(list_cmd_t'(s_tdata)));
        if (list_len > peak_len) peak_len = list_len;
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_queue.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(cmd_queue[0].mode)) begin
          s_tvalid    <= 1'b1;
          s_tdata     <= cmd_queue[0].cmd;
          active_mode <= cmd_queue[0].mode;
          void'(cmd_queue.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and result checking
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= receiver_stall_pct(active_mode);
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, m_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("ok", 64'(want.ok), 64'(m_tdata[0]));
          check_field("read_data", 64'(want.read_data), 64'(m_tdata[32:1]));
          check_field("length", 64'(want.length), 64'(m_tdata[37:33]));
          check_field("pad", 64'(0), 64'(m_tdata[39:38]));
          checked++;
          if (!want.ok) refused++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("%0t ns: no transaction for %0d cycles", $time, StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned           made, run, k, n, pos;
    seq_style_t            style;
    logic [ActionWidth-1:0] act;
    idle_mode_t            mode;

    // empty list corner cases and refused codes
    queue_cmd(ACT_INSERT, 0, AllOnes, IDLE_NONE);
    queue_cmd(ACT_REMOVE, 1, '0, IDLE_NONE);
    queue_cmd(ACT_REVERSE, 0, '0, IDLE_NONE);
    queue_cmd(ACT_CLEAR, 31, AllOnes, IDLE_NONE);
    queue_cmd(ACT_SPARE_6, 1, $urandom, IDLE_NONE);
    queue_cmd(ACT_SPARE_7, 31, AllOnes, IDLE_NONE);
    // fill to capacity at front, back and middle while the direction bit is set
    for (n = 0; n < Depth; n++) begin
      pos = (n % 3 == 0) ? 1 : (n % 3 == 1) ? n + 1 : n / 2 + 1;
      queue_cmd(ACT_INSERT, pos, (n == 0) ? '0 : (n == 1) ? AllOnes : $urandom, IDLE_NONE);
    end
    queue_cmd(ACT_INSERT, Depth + 1, $urandom, IDLE_NONE);
    queue_cmd(ACT_READ, Depth, '0, IDLE_NONE);
    queue_cmd(ACT_REVERSE, 0, '0, IDLE_NONE);
    queue_cmd(ACT_READ, 1, '0, IDLE_NONE);
    queue_cmd(ACT_REMOVE, 1, '0, IDLE_NONE);
    queue_cmd(ACT_INSERT, 1, $urandom, IDLE_NONE);
    queue_cmd(ACT_CLEAR, 0, '0, IDLE_NONE);

    // random runs, mostly legal positions, with idle modes stepping through the run
    made = 0;
    while (made < RandomItems) begin
      n     = $urandom_range(0, 99);
      style = (n < 10) ? SEQ_NOISE : (n < 40) ? SEQ_GROW : (n < 60) ? SEQ_SHRINK : SEQ_MIXED;
      run   = $urandom_range(6, 30);
      for (k = 0; k < run && made < RandomItems; k++) begin
        mode = mode_plan[made * 5 / RandomItems];
        if (style == SEQ_NOISE) begin
          act = ActionWidth'($urandom_range(0, 7));
          pos = $urandom_range(0, 31);
        end else begin
          act = pick_action(style);
          pos = pick_position(act);
        end
        queue_cmd(act, pos, pick_value(), mode);
        made++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d results checked, %0d refused, peak length %0d of %0d",
             checked, refused, peak_len, Depth);
    $display("ran with no idling, sender gaps, receiver stalls and both; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
